[src/sfm_pkg.sv]
// Package for the streaming first-match substring search.
// Holds sizes, configuration register codes, lane control type and the needle byte helper.
// No dependencies.
package sfm_pkg;

  localparam int NEEDLE_MAX   = 16;
  localparam int WIN_DEPTH    = NEEDLE_MAX - 1;
  localparam int MAX_HAYSTACK = 65536;
  localparam int CNT_W        = $clog2(MAX_HAYSTACK) + 1;
  localparam int OFF_W        = 16;
  localparam int LEN_W        = 5;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LOW    = 2'd0,
    CFG_NEEDLE_HIGH   = 2'd1,
    CFG_NEEDLE_LENGTH = 2'd2
  } sfm_cfg_idx_e;

  // Per-lane compare setup: expected needle byte and lane enable
  typedef struct packed {
    logic [7:0] pat;
    logic       active;
  } sfm_lane_ctl_t;

  // Pick needle byte idx out of the two needle words
  function automatic logic [7:0] needle_byte(input logic [CFG_W-1:0] lo,
                                             input logic [CFG_W-1:0] hi,
                                             input logic [3:0]       idx);
    logic [CFG_W-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

[src/sfm_if.sv]
// Stream interfaces for the substring search: haystack bytes in, results out.
// Depends on sfm_pkg for field widths.
interface sfm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hay_byte;
  logic       hay_last;

  modport source (output valid, output hay_byte, output hay_last, input ready);
  modport sink   (input valid, input hay_byte, input hay_last, output ready);
endinterface

interface sfm_out_if;
  import sfm_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [OFF_W-1:0] match_offset;
  logic             length_overflow;

  modport source (output valid, output found, output match_offset,
                  output length_overflow, input ready);
  modport sink   (input valid, input found, input match_offset,
                  input length_overflow, output ready);
endinterface

[src/sfm_cell.sv]
// One window cell: holds one past haystack byte and compares it with its needle byte.
// Depends on sfm_pkg for the lane control type.
module sfm_cell
  import sfm_pkg::*;
(
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic [7:0]    byte_i,
  input  sfm_lane_ctl_t ctl_i,
  output logic [7:0]    byte_o,
  output logic          hit_o
);

  logic [7:0] byte_q;

  // Take the neighbor's byte on each shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // Inactive lanes never block a match
  assign hit_o  = !ctl_i.active || (byte_q == ctl_i.pat);

endmodule

[src/substring_first_match.sv]
// Top level of the streaming first-match substring search.
// Depends on sfm_pkg, sfm_in_if, sfm_out_if and sfm_cell.
//
//   channel  | dir | transfer when       | payload
//   ---------+-----+---------------------+------------------------------------------
//   hay_i    | in  | valid && ready      | hay_byte[7:0], hay_last
//   res_o    | out | valid && ready      | found, match_offset[15:0], length_overflow
//   cfg      | in  | cfg_we_i            | cfg_idx_i[1:0], cfg_data_i[63:0]
//
// One haystack byte per cycle while hay_i.ready is high; the compare over the
// 15-cell window and the current byte settles in the cycle of the transfer.
// The result of a last byte appears in the output register the next cycle.
// hay_i.ready drops only while a result waits in the output register and res_o is stalled.
// Reset clears needle registers, counters, state flags and output valid; window bytes and result fields need none.
module substring_first_match
  import sfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sfm_in_if.sink               hay_i,
  sfm_out_if.source            res_o
);

  logic [CFG_W-1:0] needle_lo_q, needle_hi_q;
  logic [LEN_W-1:0] needle_len_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seen_q, seen_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q;
  logic             out_found_q, out_ovf_q;
  logic [OFF_W-1:0] out_off_q;

  logic             in_xfer, in_range, shift, len_ok, enough, match_now;
  sfm_lane_ctl_t    lane_ctl [NEEDLE_MAX];
  logic [7:0]       win_byte [WIN_DEPTH+1];
  logic [NEEDLE_MAX-1:0] hits;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_lo_q  <= '0;
      needle_hi_q  <= '0;
      needle_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEEDLE_LOW:    needle_lo_q  <= cfg_data_i;
        CFG_NEEDLE_HIGH:   needle_hi_q  <= cfg_data_i;
        CFG_NEEDLE_LENGTH: needle_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign hay_i.ready = !out_valid_q || res_o.ready;
  assign in_xfer     = hay_i.valid && hay_i.ready;
  assign in_range    = !cnt_q[CNT_W-1];
  assign shift       = in_xfer && in_range;

  // Lane k checks needle byte len-1-k, active while k < len
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      idx                = needle_len_q - LEN_W'(1) - LEN_W'(k);
      lane_ctl[k].active = LEN_W'(k) < needle_len_q;
      lane_ctl[k].pat    = needle_byte(needle_lo_q, needle_hi_q, idx[3:0]);
    end
  end

  // Lane zero compares the incoming byte directly
  assign win_byte[0] = hay_i.hay_byte;
  assign hits[0]     = !lane_ctl[0].active || (hay_i.hay_byte == lane_ctl[0].pat);

  // Window cells, most recent byte in cell one
  for (genvar g = 1; g <= WIN_DEPTH; g++) begin : g_cell
    sfm_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .byte_i (win_byte[g-1]),
      .ctl_i  (lane_ctl[g]),
      .byte_o (win_byte[g]),
      .hit_o  (hits[g])
    );
  end

  assign len_ok    = (needle_len_q != '0) && (needle_len_q <= LEN_W'(NEEDLE_MAX));
  assign enough    = ({1'b0, cnt_q} + (CNT_W+1)'(1)) >= (CNT_W+1)'(needle_len_q);
  assign match_now = len_ok && enough && (&hits);

  // Next per-haystack state
  always_comb begin
    cnt_d  = cnt_q;
    seen_d = seen_q;
    off_d  = off_q;
    ovf_d  = ovf_q;
    if (in_xfer) begin
      if (!in_range) begin
        ovf_d = 1'b1;
      end else begin
        if (!seen_q && !ovf_q && match_now) begin
          seen_d = 1'b1;
          off_d  = cnt_q[OFF_W-1:0] + OFF_W'(1) - OFF_W'(needle_len_q);
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // Hold per-haystack state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      seen_q <= 1'b0;
      off_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (in_xfer && hay_i.hay_last) begin
      cnt_q  <= '0;
      seen_q <= 1'b0;
      off_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      off_q  <= off_d;
      ovf_q  <= ovf_d;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && hay_i.hay_last) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result on the last byte
  always_ff @(posedge clk_i) begin
    if (in_xfer && hay_i.hay_last) begin
      out_found_q <= seen_d;
      out_off_q   <= seen_d ? off_d : '0;
      out_ovf_q   <= ovf_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.found           = out_found_q;
  assign res_o.match_offset    = out_off_q;
  assign res_o.length_overflow = out_ovf_q;

endmodule

[src/sfm_checker.sv]
// Port-level checks for substring_first_match, attached by bind.
// Depends on sfm_pkg for field widths.
module sfm_checker
  import sfm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_last_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_found_i,
  input logic [OFF_W-1:0] out_offset_i,
  input logic             out_ovf_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_found_i) && $stable(out_offset_i) && $stable(out_ovf_i))
    else $error("result changed while stalled");

  // Offset is zero when nothing was found
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_offset_i == '0)
    else $error("nonzero offset without match");

  // Input backpressure only from a waiting result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without pending result");

  // A last byte transfer yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("missing result after last byte");

endmodule

bind substring_first_match sfm_checker u_sfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hay_i.valid),
  .in_ready_i  (hay_i.ready),
  .in_last_i   (hay_i.hay_last),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_found_i (res_o.found),
  .out_offset_i(res_o.match_offset),
  .out_ovf_i   (res_o.length_overflow)
);
